@@ sv/psp_pkg.sv @@
// ----------------------------------------------------------------------------
// psp_pkg
// shared types and constants of the paged slot pool allocator
// ----------------------------------------------------------------------------
`default_nettype none

package psp_pkg;

    // default geometry of the pool
    localparam int MAX_PAGES_DEF = 16;
    localparam int MAX_SLOTS_DEF = 512;

    // smallest legal slot size in bytes
    localparam int MIN_OBJ_BYTES = 4;

    // slots per page after reset
    localparam logic [9:0] RESET_SLOTS = 10'd512;

    // configuration register indexes
    localparam logic CFG_SLOTS_PER_PAGE = 1'b0;
    localparam logic CFG_OBJECT_BYTES   = 1'b1;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_NO_PAGE  = 2'd2,
        ST_IGNORED  = 2'd3
    } t_status;

    // result handed from the sequencer to the output stage
    typedef struct packed {
        t_status    status;
        logic [3:0] page;
        logic [8:0] slot;
        logic       use_off;
    } t_res;

endpackage

`default_nettype wire

@@ sv/paged_slot_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// paged_slot_pool_allocator
// fixed-size slot allocator over a pool of pages with per-page free lists
// ----------------------------------------------------------------------------
// usage
//   input channel (i_valid / o_ready) carries one request: allocate, free a
//   given page and slot, or release all pages. every request gives exactly
//   one result on the output channel (o_valid / i_ready) with status, page,
//   slot, byte offset and the running totals.
//   configuration channel (i_cfg_valid / o_cfg_ready) writes slots_per_page
//   (index 0) and object_bytes (index 1); writes are dropped while any page
//   is open. o_cfg_ready is always high.
// sequencing
//   one request at a time; an allocate scans the open pages in order and takes a slot from the
//   first page with room, or opens a new page when none has room and one is left; a free checks
//   the slot and pushes it back; release, invalid and unused requests go straight to the result.
//   the next request is taken only after the result has left the sequencer for the output register.
// reset
//   synchronous, active low: no pages open, totals zero, slots_per_page 512,
//   object_bytes 0. the page table and slot memory need no clearing pass.
// stall
//   a finished result sits in the output register; the next request is taken
//   while it waits, and its result holds in the sequencer until the output
//   register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module paged_slot_pool_allocator #(
    parameter int MAX_PAGES = psp_pkg::MAX_PAGES_DEF,
    parameter int MAX_SLOTS = psp_pkg::MAX_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [3:0]  i_free_page,
    input  wire logic [8:0]  i_free_slot,
    // result channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [3:0]       o_page_index,
    output logic [8:0]       o_slot_index,
    output logic [24:0]      o_byte_offset,
    output logic [13:0]      o_objects_in_use,
    output logic [4:0]       o_pages_open,
    // configuration channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    import psp_pkg::*;

    localparam int OW  = $clog2(MAX_PAGES + 1);
    localparam int IUW = $clog2(MAX_PAGES * MAX_SLOTS + 1);

    // configuration registers
    logic [9:0]      r_spp;
    logic [15:0]     r_obj_bytes;
    logic            cfg_bad;

    // sequencer side
    logic [OW-1:0]   w_open;
    logic [IUW-1:0]  w_in_use;
    t_res            w_res;
    logic            w_res_valid;
    logic            res_take;

    // result register
    logic            r_out_valid;
    logic [1:0]      r_status;
    logic [3:0]      r_page;
    logic [8:0]      r_slot;
    logic [24:0]     r_offset;
    logic [13:0]     r_in_use_out;
    logic [4:0]      r_open_out;

    assign o_cfg_ready = 1'b1;

    // settings are frozen while pages are open
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spp       <= RESET_SLOTS;
            r_obj_bytes <= '0;
        end else if (i_cfg_valid && (w_open == '0)) begin
            case (i_cfg_index)
                CFG_SLOTS_PER_PAGE: r_spp       <= i_cfg_data[9:0];
                CFG_OBJECT_BYTES:   r_obj_bytes <= i_cfg_data;
                default:            r_spp       <= r_spp;
            endcase
        end
    end

    // allocation is refused for tiny slots or a page size out of range
    assign cfg_bad = (32'(r_obj_bytes) < 32'(MIN_OBJ_BYTES))
                  || (r_spp == '0)
                  || (32'(r_spp) > 32'(MAX_SLOTS));

    psp_ctrl #(
        .MAX_PAGES (MAX_PAGES),
        .MAX_SLOTS (MAX_SLOTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_valid),
        .o_req_ready (o_ready),
        .i_cmd       (i_cmd),
        .i_free_page (i_free_page),
        .i_free_slot (i_free_slot),
        .i_spp       (r_spp),
        .i_cfg_bad   (cfg_bad),
        .o_open      (w_open),
        .o_in_use    (w_in_use),
        .o_res       (w_res),
        .o_res_valid (w_res_valid),
        .i_res_take  (res_take)
    );

    // output register is free when empty or being drained this cycle
    assign res_take = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && res_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_valid && res_take) begin
            r_status     <= w_res.status;
            r_page       <= w_res.page;
            r_slot       <= w_res.slot;
            // byte offset from the slot multiplier, zero for results without one
            r_offset     <= w_res.use_off ? 25'(w_res.slot) * 25'(r_obj_bytes) : 25'd0;
            r_in_use_out <= 14'(w_in_use);
            r_open_out   <= 5'(w_open);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_page_index     = r_page;
    assign o_slot_index     = r_slot;
    assign o_byte_offset    = r_offset;
    assign o_objects_in_use = r_in_use_out;
    assign o_pages_open     = r_open_out;

    // checks

    // an accepted request keeps the sequencer busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("sequencer took a request without leaving idle");

    // open page count never passes the pool size
    a_open_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(w_open) <= 32'(MAX_PAGES)))
        else $error("more pages open than the pool holds");

    // no pages open means no slots in use
    a_empty_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_open == '0) |-> (w_in_use == '0))
        else $error("slots in use with no page open");

    // the total moves by one slot per request or drops to zero on release
    a_in_use_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_use != $past(w_in_use)) |->
            ((w_in_use == $past(w_in_use) + IUW'(1)) ||
             (w_in_use == $past(w_in_use) - IUW'(1)) ||
             (w_in_use == '0)))
        else $error("slot total jumped by more than one");

endmodule

`default_nettype wire

@@ sv/psp_ram.sv @@
// ----------------------------------------------------------------------------
// psp_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module psp_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [2**ADDR_W];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/psp_ctrl.sv @@
// ----------------------------------------------------------------------------
// psp_ctrl
// request sequencer: page scan, free list pop and push, page open
// ----------------------------------------------------------------------------
`default_nettype none

module psp_ctrl #(
    parameter int MAX_PAGES = 16,
    parameter int MAX_SLOTS = 512,
    localparam int OW  = $clog2(MAX_PAGES + 1),
    localparam int IUW = $clog2(MAX_PAGES * MAX_SLOTS + 1)
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_req_valid,
    output logic              o_req_ready,
    input  wire logic [1:0]   i_cmd,
    input  wire logic [3:0]   i_free_page,
    input  wire logic [8:0]   i_free_slot,
    input  wire logic [9:0]   i_spp,
    input  wire logic         i_cfg_bad,
    output logic [OW-1:0]     o_open,
    output logic [IUW-1:0]    o_in_use,
    output psp_pkg::t_res     o_res,
    output logic              o_res_valid,
    input  wire logic         i_res_take
);

    import psp_pkg::*;

    localparam int PW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int SW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW   = $clog2(MAX_SLOTS + 1);
    localparam int PTW  = 1 + SW + 2 * CW;
    localparam int SLW  = SW + 2;
    localparam int CMPW = (CW > 10) ? CW : 10;
    localparam int FCW  = (OW > 4) ? OW : 4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LINK,
        S_OPEN,
        S_FCHK,
        S_DONE
    } t_state;

    t_state          r_state, n_state;
    logic [PW-1:0]   r_p, n_p;
    logic [SW-1:0]   r_slot, n_slot;
    logic [3:0]      r_fpage, n_fpage;
    logic [8:0]      r_fslot, n_fslot;
    logic [OW-1:0]   r_open, n_open;
    logic [IUW-1:0]  r_in_use, n_in_use;
    t_res            r_res, n_res;

    // page table: head is fresh flag plus slot, w counts slots taken from the fresh run
    logic            pt_we;
    logic [PTW-1:0]  pt_wdata, pt_rdata;
    logic            pt_fresh;
    logic [SW-1:0]   pt_head;
    logic [CW-1:0]   pt_w, pt_cnt;

    // slot memory: next link (fresh flag plus slot) and used bit
    logic            sl_we;
    logic [SW-1:0]   sl_wslot;
    logic [SLW-1:0]  sl_wdata, sl_rdata;
    logic            sl_fresh;
    logic [SW-1:0]   sl_link;
    logic            sl_used;

    logic            free_bad;
    logic            free_used;

    assign pt_fresh = pt_rdata[PTW-1];
    assign pt_head  = pt_rdata[PTW-2 -: SW];
    assign pt_w     = pt_rdata[2*CW-1 -: CW];
    assign pt_cnt   = pt_rdata[CW-1:0];

    assign sl_fresh = sl_rdata[SLW-1];
    assign sl_link  = sl_rdata[SLW-2 -: SW];
    assign sl_used  = sl_rdata[0];

    psp_ram #(
        .WIDTH  (PTW),
        .ADDR_W (PW)
    ) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (pt_we),
        .i_waddr (r_p),
        .i_wdata (pt_wdata),
        .i_raddr (n_p),
        .o_rdata (pt_rdata)
    );

    psp_ram #(
        .WIDTH  (SLW),
        .ADDR_W (PW + SW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (sl_we),
        .i_waddr ({r_p, sl_wslot}),
        .i_wdata (sl_wdata),
        .i_raddr ({n_p, n_slot}),
        .o_rdata (sl_rdata)
    );

    // slots at or above the fresh mark were never handed out since the page opened
    assign free_bad  = !(FCW'(r_fpage) < FCW'(r_open)) || !({1'b0, r_fslot} < i_spp);
    assign free_used = (CMPW'(r_fslot) < CMPW'(pt_w)) && sl_used;

    always_comb begin
        n_state  = r_state;
        n_p      = r_p;
        n_slot   = r_slot;
        n_fpage  = r_fpage;
        n_fslot  = r_fslot;
        n_open   = r_open;
        n_in_use = r_in_use;
        n_res    = r_res;
        pt_we    = 1'b0;
        pt_wdata = '0;
        sl_we    = 1'b0;
        sl_wslot = r_slot;
        sl_wdata = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_res = '{status: ST_OK, page: 4'd0, slot: 9'd0, use_off: 1'b0};
                    case (t_cmd'(i_cmd))
                        CMD_ALLOC: begin
                            if (i_cfg_bad) begin
                                n_res.status = ST_INVALID;
                                n_state      = S_DONE;
                            end else if (r_open == '0) begin
                                n_p     = '0;
                                n_state = S_OPEN;
                            end else begin
                                n_p     = '0;
                                n_state = S_SCAN;
                            end
                        end
                        CMD_FREE: begin
                            n_p     = PW'(i_free_page);
                            n_slot  = SW'(i_free_slot);
                            n_fpage = i_free_page;
                            n_fslot = i_free_slot;
                            n_state = S_FCHK;
                        end
                        CMD_RELEASE: begin
                            n_open   = '0;
                            n_in_use = '0;
                            n_state  = S_DONE;
                        end
                        default: begin
                            n_res.status = ST_IGNORED;
                            n_state      = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (CMPW'(pt_cnt) < CMPW'(i_spp)) begin
                    n_slot  = pt_fresh ? pt_w[SW-1:0] : pt_head;
                    n_state = S_LINK;
                end else if (OW'(r_p) + OW'(1) == r_open) begin
                    if (r_open == OW'(MAX_PAGES)) begin
                        n_res.status = ST_NO_PAGE;
                        n_state      = S_DONE;
                    end else begin
                        n_p     = PW'(r_open);
                        n_state = S_OPEN;
                    end
                end else begin
                    n_p = r_p + PW'(1);
                end
            end
            S_LINK: begin
                // pop the head: fresh run advances, otherwise follow the stored link
                pt_we    = 1'b1;
                pt_wdata = pt_fresh ? {1'b1, pt_head, pt_w + CW'(1), pt_cnt + CW'(1)}
                                    : {sl_fresh, sl_link, pt_w, pt_cnt + CW'(1)};
                sl_we    = 1'b1;
                sl_wdata = {sl_fresh, sl_link, 1'b1};
                n_in_use = r_in_use + IUW'(1);
                n_res    = '{status: ST_OK, page: 4'(r_p), slot: 9'(r_slot), use_off: 1'b1};
                n_state  = S_DONE;
            end
            S_OPEN: begin
                // new page hands out slot zero at once
                pt_we    = 1'b1;
                pt_wdata = {1'b1, SW'(0), CW'(1), CW'(1)};
                sl_we    = 1'b1;
                sl_wslot = '0;
                sl_wdata = {1'b1, SW'(0), 1'b1};
                n_open   = r_open + OW'(1);
                n_in_use = r_in_use + IUW'(1);
                n_res    = '{status: ST_OK, page: 4'(r_p), slot: 9'd0, use_off: 1'b0};
                n_state  = S_DONE;
            end
            S_FCHK: begin
                n_res = '{status: ST_IGNORED, page: r_fpage, slot: r_fslot, use_off: 1'b0};
                if (!free_bad && free_used) begin
                    pt_we    = 1'b1;
                    pt_wdata = {1'b0, r_slot, pt_w, pt_cnt - CW'(1)};
                    sl_we    = 1'b1;
                    sl_wdata = {pt_fresh, pt_head, 1'b0};
                    n_in_use = r_in_use - IUW'(1);
                    n_res.status  = ST_OK;
                    n_res.use_off = 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_open   <= '0;
            r_in_use <= '0;
            r_p      <= '0;
        end else begin
            r_state  <= n_state;
            r_open   <= n_open;
            r_in_use <= n_in_use;
            r_p      <= n_p;
        end
        r_slot  <= n_slot;
        r_fpage <= n_fpage;
        r_fslot <= n_fslot;
        r_res   <= n_res;
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;
    assign o_open      = r_open;
    assign o_in_use    = r_in_use;

endmodule

`default_nettype wire

@@ dv/tb_paged_slot_pool_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_paged_slot_pool_allocator
// self-checking bench: a mirror of the page pool predicts every result, and
// directed and random requests run under random idling on both sides
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_paged_slot_pool_allocator;

    import psp_pkg::*;

    localparam int POOL_SLOTS     = MAX_PAGES_DEF * MAX_SLOTS_DEF;
    // a correct run never goes this long without some handshake
    localparam int WATCHDOG_LIMIT = 2000;

    // one result as the block reports it
    typedef struct packed {
        t_status     status;
        logic [3:0]  page;
        logic [8:0]  slot;
        logic [24:0] offset;
        logic [13:0] in_use;
        logic [4:0]  pages;
    } t_pool_result;

    // mirror of the pool state and queue of results still owed by the block
    class pool_mirror;
        bit [9:0]     link [POOL_SLOTS];
        bit           used [POOL_SLOTS];
        bit [9:0]     head [MAX_PAGES_DEF];
        bit [9:0]     cnt [MAX_PAGES_DEF];
        int           npages;
        bit [9:0]     spp;
        bit [15:0]    obytes;
        t_pool_result due [$];
        int           errors;
        int           seen;

        function new();
            spp    = RESET_SLOTS;
            obytes = '0;
            npages = 0;
            errors = 0;
            seen   = 0;
        endfunction

        // register writes only land while no page is open
        function void take_config(logic idx, logic [15:0] data);
            if (npages != 0)
                return;
            if (idx == CFG_SLOTS_PER_PAGE)
                spp = data[9:0];
            else
                obytes = data;
        endfunction

        function void push_result(t_status st, logic [3:0] pg, logic [8:0] sl,
                                  logic [24:0] off);
            t_pool_result r;
            int           total;
            int           p;
            total = 0;
            for (p = 0; p < npages; p++)
                total += cnt[p];
            r.status = st;
            r.page   = pg;
            r.slot   = sl;
            r.offset = off;
            r.in_use = 14'(total);
            r.pages  = 5'(npages);
            due.push_back(r);
        endfunction

        function void take_request(t_cmd cmd, logic [3:0] fpage, logic [8:0] fslot);
            int       p;
            int       i;
            int       base;
            int       idx;
            bit [9:0] sl;
            case (cmd)
                CMD_ALLOC: begin
                    if (obytes < MIN_OBJ_BYTES || spp == 0 || spp > MAX_SLOTS_DEF) begin
                        push_result(ST_INVALID, '0, '0, '0);
                        return;
                    end
                    // first open page with room
                    p = 0;
                    while (p < npages && cnt[p] >= spp)
                        p++;
                    if (p == npages) begin
                        if (npages >= MAX_PAGES_DEF) begin
                            push_result(ST_NO_PAGE, '0, '0, '0);
                            return;
                        end
                        // fresh page: free list in slot order
                        for (i = 0; i < spp; i++)
                            link[p * MAX_SLOTS_DEF + i] = 10'(i + 1);
                        head[p] = '0;
                        cnt[p]  = '0;
                        npages++;
                    end
                    sl = head[p];
                    if (sl >= MAX_SLOTS_DEF)
                        sl = '0;
                    base = p * MAX_SLOTS_DEF;
                    head[p] = link[base + int'(sl)];
                    used[base + int'(sl)] = 1'b1;
                    cnt[p]++;
                    push_result(ST_OK, 4'(p), 9'(sl), 25'(int'(sl) * int'(obytes)));
                end
                CMD_FREE: begin
                    if (int'(fpage) >= npages || fslot >= spp) begin
                        push_result(ST_IGNORED, fpage, fslot, '0);
                        return;
                    end
                    idx = int'(fpage) * MAX_SLOTS_DEF + int'(fslot);
                    // double free leaves the state alone
                    if (!used[idx]) begin
                        push_result(ST_IGNORED, fpage, fslot, '0);
                        return;
                    end
                    used[idx]   = 1'b0;
                    link[idx]   = head[fpage];
                    head[fpage] = 10'(fslot);
                    cnt[fpage]--;
                    push_result(ST_OK, fpage, fslot, 25'(int'(fslot) * int'(obytes)));
                end
                CMD_RELEASE: begin
                    for (i = 0; i < POOL_SLOTS; i++)
                        used[i] = 1'b0;
                    for (i = 0; i < MAX_PAGES_DEF; i++)
                        cnt[i] = '0;
                    npages = 0;
                    push_result(ST_OK, '0, '0, '0);
                end
                default: begin
                    push_result(ST_IGNORED, '0, '0, '0);
                end
            endcase
        endfunction

        // picks a random allocated slot among the open pages
        function bit pick_used(output logic [3:0] pg, output logic [8:0] sl);
            int total;
            int k;
            int p;
            int s;
            total = 0;
            pg = '0;
            sl = '0;
            for (p = 0; p < npages; p++)
                for (s = 0; s < MAX_SLOTS_DEF; s++)
                    if (used[p * MAX_SLOTS_DEF + s])
                        total++;
            if (total == 0)
                return 1'b0;
            k = $urandom_range(0, total - 1);
            for (p = 0; p < npages; p++)
                for (s = 0; s < MAX_SLOTS_DEF; s++)
                    if (used[p * MAX_SLOTS_DEF + s]) begin
                        if (k == 0) begin
                            pg = 4'(p);
                            sl = 9'(s);
                            return 1'b1;
                        end
                        k--;
                    end
            return 1'b0;
        endfunction

        task note_mismatch(string msg);
            $display("result %0d: %s", seen, msg);
            errors++;
        endtask

        task check_result(t_pool_result got);
            t_pool_result want;
            seen++;
            if (due.size() == 0) begin
                note_mismatch($sformatf("arrived with no request pending, status %0d",
                                        got.status));
                return;
            end
            want = due.pop_front();
            if (got.status !== want.status)
                note_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.page !== want.page)
                note_mismatch($sformatf("page %0d, expected %0d", got.page, want.page));
            if (got.slot !== want.slot)
                note_mismatch($sformatf("slot %0d, expected %0d", got.slot, want.slot));
            if (got.offset !== want.offset)
                note_mismatch($sformatf("byte offset %0d, expected %0d",
                                        got.offset, want.offset));
            if (got.in_use !== want.in_use)
                note_mismatch($sformatf("objects in use %0d, expected %0d",
                                        got.in_use, want.in_use));
            if (got.pages !== want.pages)
                note_mismatch($sformatf("pages open %0d, expected %0d",
                                        got.pages, want.pages));
        endtask
    endclass

    // clock, reset and every block input start at known values
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    logic [1:0]  req_cmd   = CMD_NONE;
    logic [3:0]  req_page  = '0;
    logic [8:0]  req_slot  = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [1:0]  res_status;
    logic [3:0]  res_page;
    logic [8:0]  res_slot;
    logic [24:0] res_offset;
    logic [13:0] res_in_use;
    logic [4:0]  res_pages;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_SLOTS_PER_PAGE;
    logic [15:0] cfg_data  = '0;

    // when set, neither side idles: back to back traffic
    bit          calm = 1'b0;
    int          quiet_cycles = 0;
    pool_mirror  mirror;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    paged_slot_pool_allocator uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (req_valid),
        .o_ready          (req_ready),
        .i_cmd            (req_cmd),
        .i_free_page      (req_page),
        .i_free_slot      (req_slot),
        .o_valid          (res_valid),
        .i_ready          (res_ready),
        .o_status         (res_status),
        .o_page_index     (res_page),
        .o_slot_index     (res_slot),
        .o_byte_offset    (res_offset),
        .o_objects_in_use (res_in_use),
        .o_pages_open     (res_pages),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    // idle cycles before the next request or result
    function automatic int draw_gap();
        if (calm)
            return 0;
        return int'($urandom_range(0, 16));
    endfunction

    // one request: optional idle gap, then hold valid until taken;
    // valid stays high afterwards so a zero gap gives back to back requests
    task automatic send_request(t_cmd cmd, logic [3:0] pg, logic [8:0] sl);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_cmd   <= cmd;
        req_page  <= pg;
        req_slot  <= sl;
        do @(posedge clk); while (!req_ready);
        mirror.take_request(cmd, pg, sl);
    endtask

    // stop requesting and wait for every owed result
    task automatic settle();
        req_valid <= 1'b0;
        while (mirror.due.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(logic idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        mirror.take_config(idx, data);
    endtask

    // both registers back to back, block idle
    task automatic set_config(logic [15:0] spp_data, logic [15:0] ob_data);
        cfg_write(CFG_SLOTS_PER_PAGE, spp_data);
        cfg_write(CFG_OBJECT_BYTES, ob_data);
        cfg_valid <= 1'b0;
    endtask

    // mostly allocate and free of live slots, some bad frees, rare release and unused command
    task automatic random_request(int alloc_pct);
        int         r;
        int         pick;
        logic [3:0] pg;
        logic [8:0] sl;
        logic [3:0] live_pg;
        logic [8:0] live_sl;
        r  = $urandom_range(0, 99);
        pg = 4'($urandom_range(0, 15));
        sl = 9'($urandom_range(0, 511));
        if (r < alloc_pct) begin
            send_request(CMD_ALLOC, pg, sl);
        end else if (r < 98) begin
            pick = $urandom_range(0, 3);
            if (pick < 3 && mirror.pick_used(live_pg, live_sl)) begin
                send_request(CMD_FREE, live_pg, live_sl);
            end else begin
                // near the edges: page up to one past the last open page, slot up to slots_per_page
                if (pick % 2 == 1) begin
                    pg = 4'($urandom_range(0, mirror.npages));
                    sl = 9'($urandom_range(0, 511) % (mirror.spp + 1));
                end
                send_request(CMD_FREE, pg, sl);
            end
        end else if (r == 98) begin
            send_request(CMD_RELEASE, pg, sl);
        end else begin
            send_request(CMD_NONE, pg, sl);
        end
    endtask

    // close all pages so the new settings take, then random traffic
    task automatic run_phase(logic [15:0] spp_data, logic [15:0] ob_data, int n,
                             int alloc_pct, bit quiet);
        calm = quiet;
        send_request(CMD_RELEASE, '0, '0);
        settle();
        set_config(spp_data, ob_data);
        repeat (n) random_request(alloc_pct);
    endtask

    // largest page and slot size: fill page 0 up to slot 511 and spill over,
    // upper data bits of the slot count are dropped by the register
    task automatic fill_page();
        logic [3:0] live_pg;
        logic [8:0] live_sl;
        calm = 1'b0;
        send_request(CMD_RELEASE, '0, '0);
        settle();
        set_config(16'hFE00, 16'hFFFF);
        while (mirror.npages < 2) begin
            if ($urandom_range(0, 99) < 98 || !mirror.pick_used(live_pg, live_sl))
                send_request(CMD_ALLOC, '0, '0);
            else
                send_request(CMD_FREE, live_pg, live_sl);
        end
    endtask

    task automatic directed_checks();
        // reset settings: object size zero, allocate refused
        send_request(CMD_ALLOC, 4'hF, 9'h1FF);
        // unused command with every field bit set
        send_request(CMD_NONE, 4'hF, 9'h1FF);
        // free with no page open
        send_request(CMD_FREE, 4'd0, 9'd0);
        send_request(CMD_RELEASE, '0, '0);
        // object size just below the minimum
        settle();
        set_config(16'd512, 16'd3);
        send_request(CMD_ALLOC, '0, '0);
        // zero slots per page
        settle();
        set_config(16'd0, 16'd4);
        send_request(CMD_ALLOC, '0, '0);
        // slot count over the pool limit, all data bits set
        settle();
        set_config(16'hFFFF, 16'd4);
        send_request(CMD_ALLOC, '0, '0);
        settle();
        set_config(16'd513, 16'd4);
        send_request(CMD_ALLOC, '0, '0);
        // one slot per page: every allocate opens a page until none are left
        settle();
        set_config(16'd1, 16'hFFFF);
        repeat (MAX_PAGES_DEF) send_request(CMD_ALLOC, '0, '0);
        send_request(CMD_ALLOC, '0, '0);
        // slot beyond the page, good free, then the same slot again
        send_request(CMD_FREE, 4'd15, 9'd511);
        send_request(CMD_FREE, 4'd15, 9'd0);
        send_request(CMD_FREE, 4'd15, 9'd0);
        // write while pages are open must be dropped
        settle();
        set_config(16'd2, 16'd8);
        // lands in the one page with room
        send_request(CMD_ALLOC, '0, '0);
        send_request(CMD_FREE, 4'd3, 9'd0);
        send_request(CMD_RELEASE, '0, '0);
    endtask

    // result side: random stall before each result, checked on acceptance
    initial begin
        int stall;
        wait (rst_n === 1'b1);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
            mirror.check_result(t_pool_result'{status: t_status'(res_status),
                                               page: res_page, slot: res_slot,
                                               offset: res_offset, in_use: res_in_use,
                                               pages: res_pages});
        end
    end

    // watchdog: any handshake counts as progress
    always @(posedge clk) begin
        if (!rst_n || (req_valid && req_ready) || (res_valid && res_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // main sequence
    initial begin
        mirror = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        directed_checks();

        // tiny pages fill all sixteen quickly
        run_phase(16'd3, 16'd4, 60, 80, 1'b0);
        // single slot pages, no idling
        run_phase(16'd1, 16'd65535, 20, 60, 1'b1);
        fill_page();
        run_phase(16'd37, 16'd12345, 20, 60, 1'b0);
        run_phase(16'($urandom_range(2, 24)), 16'($urandom_range(4, 65535)), 20, 65, 1'b0);
        run_phase(16'd512, 16'd4, 10, 55, 1'b1);
        // settings that refuse every allocate
        run_phase(16'hFFFF, 16'd2, 10, 60, 1'b0);

        settle();
        // wait for anything stray to show up
        repeat (20) @(posedge clk);
        if (mirror.errors == 0 && mirror.due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
